// File: sv/dsli_pkg.sv
// Package for the descending sorted list insert block.
// Holds table sizing, status codes, the entry word type and the sequencer states.
// No dependencies.
package dsli_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int ID_W        = 20;
    localparam int DEG_W       = 16;
    localparam int SLOT_W      = 4;
    localparam int STATUS_W    = 3;
    localparam int POS_W       = 5;

    localparam logic [STATUS_W-1:0] ST_INSERTED   = 3'd0;
    localparam logic [STATUS_W-1:0] ST_DUPLICATE  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_REFUSED    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_READ_OK    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_READ_EMPTY = 3'd4;

    localparam logic MODE_INSERT = 1'b0;

    typedef struct packed {
        logic [DEG_W-1:0] degree;
        logic [ID_W-1:0]  id;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_READ_WAIT,
        S_DONE
    } state_t;

endpackage

// File: sv/dsli_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Width and depth come from parameters; no package dependencies.
module dsli_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: sv/descending_sorted_list_insert.sv
// Top level of the descending sorted list insert block.
// Uses dsli_pkg and one dsli_ram instance holding the (id, degree) table.
//
//  channel | direction | tdata (low bit up)                          | tuser
//  s_      | in        | item_id, item_degree, slot (40 bits)        | mode
//  m_      | out       | position, entry_count, read_id, read_degree | status
//
// One word at a time through a sequencer around the table RAM (one read port,
// one write port, one compare unit). An insert scans down from the top for its
// place and then moves the entries below it down one slot each before writing;
// a duplicate id stops the scan, and running off the end of a full table refuses it.
// Reset empties the table at once (count to zero), no clearing pass.
// The result register holds while m_tready is low; s_tready is high only when
// the sequencer is idle.
module descending_sorted_list_insert
    import dsli_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // item_id[19:0], item_degree[35:20], slot[39:36]
    input  logic        s_tuser,   // mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // position[4:0], entry_count[9:5], read_id[29:10],
                                   // read_degree[45:30], zero fill
    output logic [2:0]  m_tuser    // status
);

    state_t               state_reg, state_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [CNT_W-1:0]     k_reg, k_next;
    logic [ID_W-1:0]      id_reg, id_next;
    logic [DEG_W-1:0]     deg_reg, deg_next;
    logic [STATUS_W-1:0]  res_status_reg, res_status_next;
    logic [POS_W-1:0]     res_pos_reg, res_pos_next;
    entry_t               res_entry_reg, res_entry_next;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [STATUS_W-1:0]  m_status_reg, m_status_next;
    logic [POS_W-1:0]     m_pos_reg, m_pos_next;
    logic [CNT_W-1:0]     m_count_reg, m_count_next;
    entry_t               m_entry_reg, m_entry_next;

    logic                 ram_we;
    logic [IDX_W-1:0]     ram_waddr;
    entry_t               ram_wdata;
    logic [IDX_W-1:0]     ram_raddr;
    entry_t               ram_rdata;

    logic [ID_W-1:0]      s_id;
    logic [DEG_W-1:0]     s_deg;
    logic [SLOT_W-1:0]    s_slot;
    logic [CNT_W-1:0]     last_idx;
    logic                 out_free;

    assign s_id   = s_tdata[19:0];
    assign s_deg  = s_tdata[35:20];
    assign s_slot = s_tdata[39:36];

    assign last_idx = (count_reg < CNT_W'(TABLE_DEPTH)) ? count_reg
                                                        : CNT_W'(TABLE_DEPTH - 1);
    assign out_free = !m_tvalid_reg || m_tready;

    dsli_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        k_next          = k_reg;
        id_next         = id_reg;
        deg_next        = deg_reg;
        res_status_next = res_status_reg;
        res_pos_next    = res_pos_reg;
        res_entry_next  = res_entry_reg;
        m_tvalid_next   = m_tvalid_reg;
        m_status_next   = m_status_reg;
        m_pos_next      = m_pos_reg;
        m_count_next    = m_count_reg;
        m_entry_next    = m_entry_reg;
        ram_we          = 1'b0;
        ram_waddr       = k_reg[IDX_W-1:0];
        ram_wdata       = ram_rdata;
        ram_raddr       = k_reg[IDX_W-1:0];
        s_tready        = 1'b0;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                s_tready  = 1'b1;
                ram_raddr = s_slot[IDX_W-1:0];
                if (s_tvalid) begin
                    id_next        = s_id;
                    deg_next       = s_deg;
                    k_next         = '0;
                    res_entry_next = '0;
                    if (s_tuser == MODE_INSERT) begin
                        state_next = S_SCAN_RD;
                    end else begin
                        res_pos_next = POS_W'(s_slot);
                        if (CNT_W'(s_slot) < count_reg) begin
                            res_status_next = ST_READ_OK;
                            state_next      = S_READ_WAIT;
                        end else begin
                            res_status_next = ST_READ_EMPTY;
                            state_next      = S_DONE;
                        end
                    end
                end
            end
            S_READ_WAIT: begin
                res_entry_next = ram_rdata;
                state_next     = S_DONE;
            end
            S_SCAN_RD: begin
                if (k_reg == count_reg) begin
                    if (count_reg == CNT_W'(TABLE_DEPTH)) begin
                        res_status_next = ST_REFUSED;
                        res_pos_next    = POS_W'(TABLE_DEPTH);
                        state_next      = S_DONE;
                    end else begin
                        res_pos_next = POS_W'(count_reg);
                        k_next       = last_idx;
                        state_next   = S_SHIFT_RD;
                    end
                end else begin
                    state_next = S_SCAN_CMP;
                end
            end
            S_SCAN_CMP: begin
                if (ram_rdata.id == id_reg) begin
                    res_status_next = ST_DUPLICATE;
                    res_pos_next    = POS_W'(k_reg);
                    state_next      = S_DONE;
                end else if (ram_rdata.degree <= deg_reg) begin
                    res_pos_next = POS_W'(k_reg);
                    k_next       = last_idx;
                    state_next   = S_SHIFT_RD;
                end else begin
                    k_next     = k_reg + CNT_W'(1);
                    state_next = S_SCAN_RD;
                end
            end
            S_SHIFT_RD: begin
                if (POS_W'(k_reg) == res_pos_reg) begin
                    ram_we          = 1'b1;
                    ram_wdata       = '{degree: deg_reg, id: id_reg};
                    res_status_next = ST_INSERTED;
                    if (count_reg != CNT_W'(TABLE_DEPTH)) begin
                        count_next = count_reg + CNT_W'(1);
                    end
                    state_next = S_DONE;
                end else begin
                    ram_raddr  = IDX_W'(k_reg - CNT_W'(1));
                    state_next = S_SHIFT_WR;
                end
            end
            S_SHIFT_WR: begin
                ram_we     = 1'b1;
                k_next     = k_reg - CNT_W'(1);
                state_next = S_SHIFT_RD;
            end
            S_DONE: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_status_next = res_status_reg;
                    m_pos_next    = res_pos_reg;
                    m_count_next  = count_reg;
                    m_entry_next  = res_entry_reg;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        k_reg          <= k_next;
        id_reg         <= id_next;
        deg_reg        <= deg_next;
        res_status_reg <= res_status_next;
        res_pos_reg    <= res_pos_next;
        res_entry_reg  <= res_entry_next;
        m_status_reg   <= m_status_next;
        m_pos_reg      <= m_pos_next;
        m_count_reg    <= m_count_next;
        m_entry_reg    <= m_entry_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = {2'b00, m_entry_reg.degree, m_entry_reg.id, m_count_reg, m_pos_reg};

endmodule

// File: verif/dsli_rank_checker.sv
// Checker for the descending sorted list insert block: watches both stream channels.
// Keeps its own ranked table, predicts each result word and compares it field by field.
// Depends on dsli_pkg for widths, entry type and status codes.
`timescale 1ns / 1ps

module dsli_rank_checker
    import dsli_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [39:0] s_tdata,   // item_id[19:0], item_degree[35:20], slot[39:36]
    input  logic        s_tuser,   // mode
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [47:0] m_tdata,   // position[4:0], entry_count[9:5], read_id[29:10],
                                   // read_degree[45:30], zero fill
    input  logic [2:0]  m_tuser,   // status
    output int          error_count,
    output int          pending_words
);

    localparam int REPORT_LIMIT = 40;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [POS_W-1:0]    position;
        logic [CNT_W-1:0]    entry_count;
        logic [ID_W-1:0]     read_id;
        logic [DEG_W-1:0]    read_degree;
    } list_result_t;

    entry_t       ranked_entries [TABLE_DEPTH];
    logic [CNT_W-1:0] ranked_count;
    list_result_t pending_results [$];
    list_result_t oldest;
    int           mismatches;

    function automatic list_result_t apply_ranked_op(input logic word_mode,
                                                     input logic [ID_W-1:0] id,
                                                     input logic [DEG_W-1:0] degree,
                                                     input logic [SLOT_W-1:0] slot);
        list_result_t res;
        int           k;
        int           place;
        int           last;
        bit           dup;
        res   = '0;
        dup   = 1'b0;
        place = int'(ranked_count);
        if (word_mode != MODE_INSERT) begin
            res.position = POS_W'(slot);
            if (CNT_W'(slot) < ranked_count) begin
                res.status      = ST_READ_OK;
                res.read_id     = ranked_entries[slot].id;
                res.read_degree = ranked_entries[slot].degree;
            end else begin
                res.status = ST_READ_EMPTY;
            end
        end else begin
            for (k = 0; k < int'(ranked_count); k++) begin
                if (ranked_entries[k].id == id) begin
                    dup   = 1'b1;
                    place = k;
                    break;
                end
                if (ranked_entries[k].degree <= degree) begin
                    place = k;
                    break;
                end
            end
            if (dup) begin
                res.status   = ST_DUPLICATE;
                res.position = POS_W'(place);
            end else if (place >= TABLE_DEPTH) begin
                res.status   = ST_REFUSED;
                res.position = POS_W'(TABLE_DEPTH);
            end else begin
                last = (int'(ranked_count) < TABLE_DEPTH) ? int'(ranked_count)
                                                          : TABLE_DEPTH - 1;
                for (k = last; k > place; k--)
                    ranked_entries[k] = ranked_entries[k-1];
                ranked_entries[place].id     = id;
                ranked_entries[place].degree = degree;
                if (int'(ranked_count) < TABLE_DEPTH)
                    ranked_count = ranked_count + CNT_W'(1);
                res.status   = ST_INSERTED;
                res.position = POS_W'(place);
            end
        end
        res.entry_count = ranked_count;
        return res;
    endfunction

    task automatic compare_field(input string field, input int unsigned want,
                                 input int unsigned got);
        if (want != got) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $error("%s: expected 0x%0h, actual 0x%0h", field, want, got);
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            ranked_count = '0;
            pending_results.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (pending_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $error("result word with nothing pending: status 0x%0h, data 0x%0h",
                               m_tuser, m_tdata);
                end else begin
                    oldest = pending_results.pop_front();
                    compare_field("status", oldest.status, m_tuser);
                    compare_field("position", oldest.position, m_tdata[4:0]);
                    compare_field("entry_count", oldest.entry_count, m_tdata[9:5]);
                    compare_field("read_id", oldest.read_id, m_tdata[29:10]);
                    compare_field("read_degree", oldest.read_degree, m_tdata[45:30]);
                end
            end
            if (s_tvalid && s_tready)
                pending_results.push_back(apply_ranked_op(s_tuser, s_tdata[19:0],
                                                          s_tdata[35:20], s_tdata[39:36]));
        end
        pending_words <= pending_results.size();
        error_count   <= mismatches;
    end

endmodule

// File: verif/tb_descending_sorted_list_insert.sv
// Testbench top for the descending sorted list insert block: clock, reset and stimulus.
// Directed words first, then random inserts and reads with bursty idling on both sides.
// Depends on dsli_pkg, descending_sorted_list_insert and dsli_rank_checker.
`timescale 1ns / 1ps

module tb_descending_sorted_list_insert;
    import dsli_pkg::*;

    localparam logic MODE_READ        = ~MODE_INSERT;
    localparam int   RANDOM_WORDS     = 1975;
    localparam int   QUIET_WORDS      = 300;
    localparam int   LONG_HOLD_CYCLES = 150;
    localparam int   TIMEOUT_NS       = 10_000_000;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;   // item_id[19:0], item_degree[35:20], slot[39:36]
    logic        s_tuser;   // mode
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;   // position[4:0], entry_count[9:5], read_id[29:10],
                            // read_degree[45:30], zero fill
    logic [2:0]  m_tuser;   // status
    int          error_count;
    int          pending_words;
    bit          quiet_phase;
    bit          sink_hold_req;

    descending_sorted_list_insert u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    dsli_rank_checker u_rank_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .error_count   (error_count),
        .pending_words (pending_words)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    task automatic offer_word(input logic word_mode, input logic [ID_W-1:0] id,
                              input logic [DEG_W-1:0] degree, input logic [SLOT_W-1:0] slot);
        if (!quiet_phase && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= word_mode;
        s_tdata  <= {slot, degree, id};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_words != 0) @(posedge aclk);
    endtask

    initial begin
        forever begin
            if (sink_hold_req) begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge aclk);
                sink_hold_req = 1'b0;
            end else if (!quiet_phase && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge aclk);
            end
        end
    end

    initial begin
        #(TIMEOUT_NS);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        int               idx;
        int               ceiling;
        logic             word_mode;
        logic [ID_W-1:0]  id;
        logic [DEG_W-1:0] degree;
        logic [SLOT_W-1:0] slot;

        quiet_phase   = 1'b0;
        sink_hold_req = 1'b0;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tuser  <= MODE_INSERT;
        s_tdata  <= '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // empty table, extremes, duplicate at top, tie, same id below insertion point
        offer_word(MODE_READ, 20'h00000, 16'h0000, 4'd0);
        offer_word(MODE_READ, 20'hFFFFF, 16'hFFFF, 4'd15);
        offer_word(MODE_INSERT, 20'hFFFFF, 16'hFFFF, 4'd15);
        offer_word(MODE_INSERT, 20'h00000, 16'h0000, 4'd0);
        offer_word(MODE_INSERT, 20'hFFFFF, 16'h0000, 4'd0);
        offer_word(MODE_INSERT, 20'h00001, 16'h0000, 4'd0);
        offer_word(MODE_INSERT, 20'h00000, 16'hFFFF, 4'd0);
        offer_word(MODE_READ, 20'h00000, 16'h0000, 4'd3);
        offer_word(MODE_READ, 20'h00000, 16'h0000, 4'd4);
        // fill the table, then displace the tail and append to a full table
        for (idx = 0; idx < 12; idx++)
            offer_word(MODE_INSERT, ID_W'(32'h00100 + idx),
                       DEG_W'(32'h9000 - 32'h0100 * idx), 4'd0);
        offer_word(MODE_INSERT, 20'h00200, 16'h4000, 4'd0);
        offer_word(MODE_INSERT, 20'h00201, 16'h4000, 4'd0);
        offer_word(MODE_INSERT, 20'h00202, 16'h0000, 4'd0);
        offer_word(MODE_READ, 20'h00000, 16'h0000, 4'd15);

        for (idx = 0; idx < RANDOM_WORDS; idx++) begin
            if (idx == 600 || idx == 1300)
                wait_drained();
            if (idx == 900)
                sink_hold_req = 1'b1;
            if (idx == RANDOM_WORDS - QUIET_WORDS)
                quiet_phase = 1'b1;

            // slide the degree window upward so inserts keep landing inside the table
            ceiling   = 16'h0400 + (idx * 32'h0000FBFF) / RANDOM_WORDS;
            word_mode = ($urandom_range(0, 3) == 0) ? MODE_READ : MODE_INSERT;
            case ($urandom_range(0, 3))
                0, 1:    id = ID_W'($urandom_range(0, 47));
                2:       id = ID_W'($urandom);
                default: id = ID_W'(32'hFFFFF - $urandom_range(0, 15));
            endcase
            case ($urandom_range(0, 7))
                0, 1:    degree = DEG_W'($urandom);
                2:       degree = DEG_W'($urandom_range(0, 255));
                3:       degree = DEG_W'((ceiling - $urandom_range(0, 16'h03FF)) & 16'hFFC0);
                default: degree = DEG_W'(ceiling - $urandom_range(0, 16'h03FF));
            endcase
            slot = SLOT_W'($urandom_range(0, 15));
            offer_word(word_mode, id, degree, slot);
        end

        wait_drained();
        repeat (40) @(posedge aclk);
        if (error_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
